FILE: hw/rtl/rtd_pkg.sv
// Shared types, constants and command encoders for the RTD temperature converter.
package rtd_pkg;

    localparam int NEWTON_STEPS = 20;
    localparam int CNT_W        = $clog2(NEWTON_STEPS + 1);
    localparam int WIDE_W       = 128;
    localparam int SH_W         = 7;

    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t K100   = wide_t'(100) <<< 32;
    localparam wide_t K300   = wide_t'(300) <<< 32;
    localparam wide_t K32768 = wide_t'(32768);
    localparam wide_t S32_LO = -(wide_t'(1) <<< 31);
    localparam wide_t S32_HI = (wide_t'(1) <<< 31) - wide_t'(1);
    localparam wide_t E47_LO = -(wide_t'(1) <<< 47);
    localparam wide_t E47_HI = (wide_t'(1) <<< 47) - wide_t'(1);

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_BAD_R0   = 3'd1;
    localparam logic [2:0] STAT_RANGE    = 3'd2;
    localparam logic [2:0] STAT_NEG_DISC = 3'd3;
    localparam logic [2:0] STAT_NO_CONV  = 3'd4;

    localparam logic [1:0] CFG_NOMINAL = 2'd0;
    localparam logic [1:0] CFG_LINEAR  = 2'd1;
    localparam logic [1:0] CFG_SQUARE  = 2'd2;
    localparam logic [1:0] CFG_QUARTIC = 2'd3;

    typedef enum logic [2:0] {OP_NONE, OP_ALU, OP_MUL, OP_DIV, OP_SQRT} op_t;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_RIN, SRC_R0, SRC_A, SRC_B, SRC_C, SRC_K100, SRC_K300,
        SRC_K32768, SRC_D, SRC_T, SRC_Y, SRC_P, SRC_G, SRC_W, SRC_X,
        SRC_AS, SRC_BS, SRC_B2S
    } src_t;

    typedef enum logic [3:0] {
        DST_D, DST_T, DST_Y, DST_P, DST_G, DST_W, DST_X, DST_AS, DST_BS,
        DST_B2S, DST_OUT
    } dst_t;

    typedef enum logic [1:0] {SAT_NONE, SAT_S32, SAT_E47} sat_t;

    typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_ROUND, DV_SIGN} div_phase_t;
    typedef enum logic [1:0] {SQ_IDLE, SQ_RUN, SQ_DONE} sqrt_phase_t;

    typedef enum logic [5:0] {
        S_IDLE, S_CHK0, S_CHK1, S_CHK2, S_CHK3, S_CHK4,
        S_L_MUL, S_L_DIV, S_L_SAT,
        S_Q_MUL, S_Q_DIV, S_Q_DISC, S_Q_CHK, S_Q_SUB, S_Q_DIV2,
        S_N_MUL0, S_N_DIV0, S_N_SAT0, S_N_DIVY, S_N_AS, S_N_BS, S_N_B2S,
        S_N_K1, S_N_M1, S_N_M2, S_N_M3, S_N_M4, S_N_K2, S_N_M5, S_N_M6, S_N_M7,
        S_N_PY, S_N_DIV, S_N_UPD, S_N_DEL, S_N_MOV, S_N_OUT,
        S_ZERO, S_DONE
    } state_t;

    typedef struct packed {
        logic            issue;
        op_t             op;
        src_t            src_a;
        src_t            src_b;
        src_t            src_c;
        dst_t            dst;
        logic [SH_W-1:0] shamt;
        logic            sub;
        logic            wrap64;
        logic            shr16;
        sat_t            sat;
        logic            rnd;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic is_zero;
        logic is_neg;
        logic is_tiny;
    } dp_stat_t;

    function automatic dp_cmd_t f_alu(dst_t dst, src_t a, src_t b, logic sub,
                                      logic [SH_W-1:0] sh, sat_t sat);
        dp_cmd_t c;
        c       = '0;
        c.issue = 1'b1;
        c.op    = OP_ALU;
        c.dst   = dst;
        c.src_a = a;
        c.src_b = b;
        c.sub   = sub;
        c.shamt = sh;
        c.sat   = sat;
        return c;
    endfunction

    function automatic dp_cmd_t f_mul(dst_t dst, src_t a, src_t b, src_t add,
                                      logic [SH_W-1:0] sh);
        dp_cmd_t c;
        c       = '0;
        c.issue = 1'b1;
        c.op    = OP_MUL;
        c.dst   = dst;
        c.src_a = a;
        c.src_b = b;
        c.src_c = add;
        c.shamt = sh;
        return c;
    endfunction

    function automatic dp_cmd_t f_div(dst_t dst, src_t a, src_t b,
                                      logic [SH_W-1:0] sh, logic rnd);
        dp_cmd_t c;
        c       = '0;
        c.issue = 1'b1;
        c.op    = OP_DIV;
        c.dst   = dst;
        c.src_a = a;
        c.src_b = b;
        c.shamt = sh;
        c.rnd   = rnd;
        return c;
    endfunction

    function automatic dp_cmd_t f_sqrt(dst_t dst, src_t a);
        dp_cmd_t c;
        c       = '0;
        c.issue = 1'b1;
        c.op    = OP_SQRT;
        c.dst   = dst;
        c.src_a = a;
        return c;
    endfunction

endpackage

FILE: hw/rtl/rtd_div.sv
// Restoring 128-bit signed divider, one quotient bit per cycle, optional rounding.
module rtd_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  rtd_pkg::wide_t num,
    input  rtd_pkg::wide_t den,
    input  logic          rnd,
    output logic          done,
    output rtd_pkg::wide_t quo
);
    import rtd_pkg::*;

    div_phase_t   phase_reg, phase_next;
    logic [6:0]   cnt_reg;
    logic [127:0] un_reg, ud_reg, rem_reg, q_reg;
    logic         neg_reg, rnd_reg;
    logic [127:0] rem_s, num_abs, den_abs;
    logic         ge;

    assign num_abs = num[127] ? 128'(-num) : 128'(num);
    assign den_abs = den[127] ? 128'(-den) : 128'(den);
    assign rem_s   = {rem_reg[126:0], un_reg[127]};
    assign ge      = rem_s >= ud_reg;
    assign done    = phase_reg == DV_SIGN;
    assign quo     = neg_reg ? -wide_t'(q_reg) : wide_t'(q_reg);

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            DV_IDLE:  if (start) phase_next = (den == '0) ? DV_SIGN : DV_RUN;
            DV_RUN:   if (cnt_reg == 7'd127) phase_next = DV_ROUND;
            DV_ROUND: phase_next = DV_SIGN;
            DV_SIGN:  phase_next = DV_IDLE;
            default:  phase_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= DV_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            DV_IDLE: begin
                if (start) begin
                    rnd_reg <= rnd;
                    un_reg  <= num_abs;
                    ud_reg  <= den_abs;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (den == '0) begin
                        // divide by zero: extreme value of the numerator's sign
                        neg_reg <= num[127];
                        q_reg   <= (num == '0) ? '0 : (128'd1 << 126);
                    end else begin
                        neg_reg <= num[127] ^ den[127];
                        q_reg   <= '0;
                    end
                end
            end
            DV_RUN: begin
                rem_reg <= ge ? rem_s - ud_reg : rem_s;
                q_reg   <= {q_reg[126:0], ge};
                un_reg  <= {un_reg[126:0], 1'b0};
                cnt_reg <= cnt_reg + 7'd1;
            end
            DV_ROUND: begin
                if (rnd_reg && (rem_reg >= ud_reg - rem_reg)) q_reg <= q_reg + 128'd1;
            end
            DV_SIGN: begin
            end
            default: begin
            end
        endcase
    end
endmodule

FILE: hw/rtl/rtd_sqrt.sv
// Digit-by-digit integer square root of a 128-bit value, one root bit per cycle.
module rtd_sqrt (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [127:0]  v,
    output logic          done,
    output logic [63:0]   root
);
    import rtd_pkg::*;

    sqrt_phase_t  phase_reg, phase_next;
    logic [5:0]   cnt_reg;
    logic [127:0] v_reg;
    logic [67:0]  rem_reg, rem_s, trial;
    logic [63:0]  root_reg;
    logic         ge;

    assign rem_s = {rem_reg[65:0], v_reg[127:126]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = rem_s >= trial;
    assign done  = phase_reg == SQ_DONE;
    assign root  = root_reg;

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            SQ_IDLE: if (start) phase_next = SQ_RUN;
            SQ_RUN:  if (cnt_reg == 6'd63) phase_next = SQ_DONE;
            SQ_DONE: phase_next = SQ_IDLE;
            default: phase_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= SQ_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == SQ_IDLE && start) begin
            v_reg    <= v;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end else if (phase_reg == SQ_RUN) begin
            rem_reg  <= ge ? rem_s - trial : rem_s;
            root_reg <= {root_reg[62:0], ge};
            v_reg    <= {v_reg[125:0], 2'b00};
            cnt_reg  <= cnt_reg + 6'd1;
        end
    end
endmodule

FILE: hw/rtl/rtd_dp.sv
// Datapath: working registers, combinational ALU, serial multiplier, divider and root.
module rtd_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_load,
    input  logic signed [31:0]      in_resistance,
    input  logic [31:0]             r0,
    input  logic signed [47:0]      coef_a,
    input  logic signed [47:0]      coef_b,
    input  logic signed [47:0]      coef_c,
    input  rtd_pkg::dp_cmd_t        cmd,
    output rtd_pkg::dp_stat_t       stat,
    output logic signed [31:0]      temperature
);
    import rtd_pkg::*;

    logic signed [31:0] r_reg, out_reg;
    wide_t d_reg, t_reg, y_reg, p_reg, g_reg, w_reg, x_reg, as_reg, bs_reg, b2s_reg;
    logic    busy_reg;
    dp_cmd_t cmd_reg;
    logic    zero_reg, neg_reg, tiny_reg;

    wide_t va, vb, vc;

    function automatic wide_t src_val(input src_t s);
        wide_t v;
        case (s)
            SRC_ZERO:   v = '0;
            SRC_RIN:    v = wide_t'(r_reg);
            SRC_R0:     v = wide_t'({96'b0, r0});
            SRC_A:      v = wide_t'(coef_a);
            SRC_B:      v = wide_t'(coef_b);
            SRC_C:      v = wide_t'(coef_c);
            SRC_K100:   v = K100;
            SRC_K300:   v = K300;
            SRC_K32768: v = K32768;
            SRC_D:      v = d_reg;
            SRC_T:      v = t_reg;
            SRC_Y:      v = y_reg;
            SRC_P:      v = p_reg;
            SRC_G:      v = g_reg;
            SRC_W:      v = w_reg;
            SRC_X:      v = x_reg;
            SRC_AS:     v = as_reg;
            SRC_BS:     v = bs_reg;
            SRC_B2S:    v = b2s_reg;
            default:    v = '0;
        endcase
        return v;
    endfunction

    assign va = src_val(cmd.src_a);
    assign vb = src_val(cmd.src_b);
    assign vc = src_val(cmd.src_c);

    logic idle_issue, alu_fire, start_multi;
    assign idle_issue  = cmd.issue && !busy_reg;
    assign alu_fire    = idle_issue && cmd.op == OP_ALU;
    assign start_multi = idle_issue && (cmd.op == OP_MUL || cmd.op == OP_DIV ||
                                        cmd.op == OP_SQRT);

    // ALU: shift, add or subtract, optional 64-bit wrap, shift down, saturate
    wide_t alu_x, alu_s, alu_res, sat_lo, sat_hi, dif_lo, dif_hi;
    always_comb begin
        alu_x = va <<< cmd.shamt;
        alu_s = cmd.sub ? alu_x - vb : alu_x + vb;
        if (cmd.wrap64) alu_s = wide_t'($signed(alu_s[63:0]));
        if (cmd.shr16) alu_s = alu_s >>> 16;
        sat_lo = (cmd.sat == SAT_S32) ? S32_LO : E47_LO;
        sat_hi = (cmd.sat == SAT_S32) ? S32_HI : E47_HI;
        dif_lo = alu_s - sat_lo;
        dif_hi = sat_hi - alu_s;
        alu_res = alu_s;
        if (cmd.sat != SAT_NONE) begin
            if (dif_lo[127]) alu_res = sat_lo;
            else if (dif_hi[127]) alu_res = sat_hi;
        end
    end

    // Multiplier: magnitude of b, seven 32x32 partial products mod 2^128
    logic [127:0] mul_a_reg, acc_reg;
    logic [63:0]  mul_b_reg;
    logic         mul_neg_reg;
    wide_t        mul_c_reg;
    logic [3:0]   mul_cnt_reg;
    logic [2:0]   k;
    logic [1:0]   li;
    logic         lj;
    logic [31:0]  la, lb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic         mul_done;
    wide_t        mul_res;

    always_comb begin
        k     = mul_cnt_reg[2:0];
        lj    = k >= 3'd4;
        li    = lj ? 2'(k - 3'd4) : k[1:0];
        la    = mul_a_reg[li*32 +: 32];
        lb    = lj ? mul_b_reg[63:32] : mul_b_reg[31:0];
        pp    = la * lb;
        pp_sh = {64'b0, pp} << (7'({li, 5'b0}) + 7'({lj, 5'b0}));
    end

    assign mul_done = busy_reg && cmd_reg.op == OP_MUL && mul_cnt_reg == 4'd8;
    assign mul_res  = mul_c_reg + (wide_t'(acc_reg) >>> cmd_reg.shamt);

    always_ff @(posedge aclk) begin
        if (start_multi && cmd.op == OP_MUL) begin
            mul_a_reg   <= 128'(va);
            mul_b_reg   <= vb[63] ? 64'(64'd0 - vb[63:0]) : vb[63:0];
            mul_neg_reg <= vb[63];
            mul_c_reg   <= vc;
            acc_reg     <= '0;
            mul_cnt_reg <= '0;
        end else if (busy_reg && cmd_reg.op == OP_MUL && mul_cnt_reg != 4'd8) begin
            if (mul_cnt_reg == 4'd7) acc_reg <= mul_neg_reg ? 128'(-acc_reg) : acc_reg;
            else acc_reg <= acc_reg + pp_sh;
            mul_cnt_reg <= mul_cnt_reg + 4'd1;
        end
    end

    // Divider and square root
    logic  div_done_raw, sqrt_done_raw, div_done, sqrt_done;
    wide_t div_quo;
    logic [63:0] sq_root;

    rtd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_multi && cmd.op == OP_DIV),
        .num     (va <<< cmd.shamt),
        .den     (vb),
        .rnd     (cmd.rnd),
        .done    (div_done_raw),
        .quo     (div_quo)
    );

    rtd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_multi && cmd.op == OP_SQRT),
        .v       (128'(va)),
        .done    (sqrt_done_raw),
        .root    (sq_root)
    );

    assign div_done  = busy_reg && cmd_reg.op == OP_DIV && div_done_raw;
    assign sqrt_done = busy_reg && cmd_reg.op == OP_SQRT && sqrt_done_raw;

    // Writeback
    logic  wb_en;
    dst_t  wb_dst;
    wide_t wb_val;
    always_comb begin
        wb_en  = 1'b1;
        wb_dst = cmd_reg.dst;
        wb_val = '0;
        priority if (alu_fire) begin
            wb_dst = cmd.dst;
            wb_val = alu_res;
        end else if (mul_done) begin
            wb_val = mul_res;
        end else if (div_done) begin
            wb_val = div_quo;
        end else if (sqrt_done) begin
            wb_val = wide_t'({64'b0, sq_root});
        end else begin
            wb_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            zero_reg <= 1'b0;
            neg_reg  <= 1'b0;
            tiny_reg <= 1'b0;
        end else begin
            if (start_multi) busy_reg <= 1'b1;
            else if (mul_done || div_done || sqrt_done) busy_reg <= 1'b0;
            if (wb_en) begin
                zero_reg <= wb_val == '0;
                neg_reg  <= wb_val[127];
                tiny_reg <= wb_val == '0 || wb_val == wide_t'(1) || wb_val == -wide_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_multi) cmd_reg <= cmd;
        if (in_load) r_reg <= in_resistance;
        if (wb_en) begin
            unique case (wb_dst)
                DST_D:   d_reg   <= wb_val;
                DST_T:   t_reg   <= wb_val;
                DST_Y:   y_reg   <= wb_val;
                DST_P:   p_reg   <= wb_val;
                DST_G:   g_reg   <= wb_val;
                DST_W:   w_reg   <= wb_val;
                DST_X:   x_reg   <= wb_val;
                DST_AS:  as_reg  <= wb_val;
                DST_BS:  bs_reg  <= wb_val;
                DST_B2S: b2s_reg <= wb_val;
                DST_OUT: out_reg <= wb_val[31:0];
                default: out_reg <= out_reg;
            endcase
        end
    end

    assign stat.done    = alu_fire || mul_done || div_done || sqrt_done;
    assign stat.is_zero = zero_reg;
    assign stat.is_neg  = neg_reg;
    assign stat.is_tiny = tiny_reg;
    assign temperature  = out_reg;
endmodule

FILE: hw/rtl/rtd_ctrl.sv
// Controller: sequences the conversion paths and owns the stream handshakes.
module rtd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_accept,
    input  logic               m_tready,
    input  rtd_pkg::dp_stat_t  stat,
    output logic               s_tready,
    output logic               m_tvalid,
    output logic [2:0]         status,
    output rtd_pkg::dp_cmd_t   cmd
);
    import rtd_pkg::*;

    state_t           state_reg, state_next;
    logic [2:0]       status_reg, status_next;
    logic [2:0]       status_out_reg, status_out_next;
    logic             m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_valid_reg;
    assign status   = status_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            status_reg     <= STAT_OK;
            status_out_reg <= STAT_OK;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            status_reg     <= status_next;
            status_out_reg <= status_out_next;
            m_valid_reg    <= m_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        status_next     = status_reg;
        status_out_next = status_out_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg;
        cmd             = '0;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    status_next = STAT_OK;
                    cnt_next    = '0;
                    state_next  = S_CHK0;
                end
            end
            S_CHK0: begin
                cmd = f_alu(DST_W, SRC_R0, SRC_ZERO, 1'b0, 7'd0, SAT_NONE);
                if (stat.done) state_next = S_CHK1;
            end
            S_CHK1: begin
                if (stat.is_zero) begin
                    status_next = STAT_BAD_R0;
                    state_next  = S_ZERO;
                end else begin
                    cmd = f_alu(DST_W, SRC_RIN, SRC_ZERO, 1'b0, 7'd0, SAT_NONE);
                    if (stat.done) state_next = S_CHK2;
                end
            end
            S_CHK2: begin
                if (stat.is_zero || stat.is_neg) begin
                    status_next = STAT_RANGE;
                    state_next  = S_ZERO;
                end else begin
                    cmd = f_alu(DST_D, SRC_RIN, SRC_R0, 1'b1, 7'd0, SAT_NONE);
                    if (stat.done) state_next = S_CHK3;
                end
            end
            S_CHK3: begin
                if (stat.is_neg) begin
                    state_next = S_N_MUL0;
                end else begin
                    cmd = f_alu(DST_W, SRC_B, SRC_ZERO, 1'b0, 7'd0, SAT_NONE);
                    if (stat.done) state_next = S_CHK4;
                end
            end
            S_CHK4: state_next = stat.is_zero ? S_L_MUL : S_Q_MUL;

            // linear path
            S_L_MUL: begin
                cmd = f_mul(DST_W, SRC_R0, SRC_A, SRC_ZERO, 7'd0);
                if (stat.done) state_next = S_L_DIV;
            end
            S_L_DIV: begin
                cmd = f_div(DST_X, SRC_D, SRC_W, 7'd56, 1'b1);
                if (stat.done) state_next = S_L_SAT;
            end
            S_L_SAT: begin
                cmd = f_alu(DST_X, SRC_X, SRC_ZERO, 1'b0, 7'd0, SAT_S32);
                if (stat.done) state_next = S_DONE;
            end

            // quadratic closed form
            S_Q_MUL: begin
                cmd = f_mul(DST_W, SRC_B, SRC_D, SRC_ZERO, 7'd0);
                if (stat.done) state_next = S_Q_DIV;
            end
            S_Q_DIV: begin
                cmd = f_div(DST_X, SRC_W, SRC_R0, 7'd30, 1'b0);
                if (stat.done) state_next = S_Q_DISC;
            end
            S_Q_DISC: begin
                cmd = f_mul(DST_P, SRC_A, SRC_A, SRC_X, 7'd0);
                if (stat.done) state_next = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (stat.is_neg) begin
                    status_next = STAT_NEG_DISC;
                    state_next  = S_ZERO;
                end else begin
                    cmd = f_sqrt(DST_W, SRC_P);
                    if (stat.done) state_next = S_Q_SUB;
                end
            end
            S_Q_SUB: begin
                // root minus A wraps in 64 bits
                cmd = f_alu(DST_W, SRC_W, SRC_A, 1'b1, 7'd0, SAT_NONE);
                cmd.wrap64 = 1'b1;
                if (stat.done) state_next = S_Q_DIV2;
            end
            S_Q_DIV2: begin
                cmd = f_div(DST_X, SRC_W, SRC_B, 7'd27, 1'b1);
                if (stat.done) state_next = S_L_SAT;
            end

            // Newton setup
            S_N_MUL0: begin
                cmd = f_mul(DST_W, SRC_R0, SRC_A, SRC_ZERO, 7'd0);
                if (stat.done) state_next = S_N_DIV0;
            end
            S_N_DIV0: begin
                cmd = f_div(DST_T, SRC_D, SRC_W, 7'd72, 1'b1);
                if (stat.done) state_next = S_N_SAT0;
            end
            S_N_SAT0: begin
                cmd = f_alu(DST_T, SRC_T, SRC_ZERO, 1'b0, 7'd0, SAT_E47);
                if (stat.done) state_next = S_N_DIVY;
            end
            S_N_DIVY: begin
                cmd = f_div(DST_Y, SRC_D, SRC_R0, 7'd56, 1'b0);
                if (stat.done) state_next = S_N_AS;
            end
            S_N_AS: begin
                cmd = f_alu(DST_AS, SRC_A, SRC_ZERO, 1'b0, 7'd16, SAT_NONE);
                if (stat.done) state_next = S_N_BS;
            end
            S_N_BS: begin
                cmd = f_alu(DST_BS, SRC_B, SRC_ZERO, 1'b0, 7'd4, SAT_NONE);
                if (stat.done) state_next = S_N_B2S;
            end
            S_N_B2S: begin
                cmd = f_alu(DST_B2S, SRC_B, SRC_ZERO, 1'b0, 7'd5, SAT_NONE);
                if (stat.done) state_next = S_N_K1;
            end

            // Newton step: polynomial by Horner, then derivative
            S_N_K1: begin
                cmd = f_alu(DST_W, SRC_T, SRC_K100, 1'b1, 7'd0, SAT_NONE);
                if (stat.done) state_next = S_N_M1;
            end
            S_N_M1: begin
                cmd = f_mul(DST_X, SRC_C, SRC_W, SRC_ZERO, 7'd48);
                if (stat.done) state_next = S_N_M2;
            end
            S_N_M2: begin
                cmd = f_mul(DST_X, SRC_X, SRC_T, SRC_BS, 7'd32);
                if (stat.done) state_next = S_N_M3;
            end
            S_N_M3: begin
                cmd = f_mul(DST_X, SRC_X, SRC_T, SRC_AS, 7'd32);
                if (stat.done) state_next = S_N_M4;
            end
            S_N_M4: begin
                cmd = f_mul(DST_P, SRC_X, SRC_T, SRC_ZERO, 7'd32);
                if (stat.done) state_next = S_N_K2;
            end
            S_N_K2: begin
                cmd = f_alu(DST_W, SRC_T, SRC_K300, 1'b1, 7'd2, SAT_NONE);
                if (stat.done) state_next = S_N_M5;
            end
            S_N_M5: begin
                cmd = f_mul(DST_X, SRC_C, SRC_W, SRC_ZERO, 7'd48);
                if (stat.done) state_next = S_N_M6;
            end
            S_N_M6: begin
                cmd = f_mul(DST_X, SRC_X, SRC_T, SRC_B2S, 7'd32);
                if (stat.done) state_next = S_N_M7;
            end
            S_N_M7: begin
                cmd = f_mul(DST_G, SRC_X, SRC_T, SRC_AS, 7'd32);
                if (stat.done) state_next = S_N_PY;
            end
            S_N_PY: begin
                if (stat.is_zero) begin
                    // flat derivative: stop with the current estimate
                    status_next = STAT_NO_CONV;
                    state_next  = S_N_OUT;
                end else begin
                    cmd = f_alu(DST_W, SRC_P, SRC_Y, 1'b1, 7'd0, SAT_NONE);
                    if (stat.done) state_next = S_N_DIV;
                end
            end
            S_N_DIV: begin
                cmd = f_div(DST_X, SRC_W, SRC_G, 7'd32, 1'b1);
                if (stat.done) state_next = S_N_UPD;
            end
            S_N_UPD: begin
                cmd = f_alu(DST_W, SRC_T, SRC_X, 1'b1, 7'd0, SAT_E47);
                if (stat.done) state_next = S_N_DEL;
            end
            S_N_DEL: begin
                cmd = f_alu(DST_X, SRC_W, SRC_T, 1'b1, 7'd0, SAT_NONE);
                if (stat.done) state_next = S_N_MOV;
            end
            S_N_MOV: begin
                cmd = f_alu(DST_T, SRC_W, SRC_ZERO, 1'b0, 7'd0, SAT_NONE);
                if (stat.done) begin
                    if (stat.is_tiny) begin
                        status_next = STAT_OK;
                        state_next  = S_N_OUT;
                    end else if (cnt_reg == CNT_W'(NEWTON_STEPS - 1)) begin
                        status_next = STAT_NO_CONV;
                        state_next  = S_N_OUT;
                    end else begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_N_K1;
                    end
                end
            end
            S_N_OUT: begin
                cmd = f_alu(DST_X, SRC_T, SRC_K32768, 1'b0, 7'd0, SAT_S32);
                cmd.shr16 = 1'b1;
                if (stat.done) state_next = S_DONE;
            end

            S_ZERO: begin
                cmd = f_alu(DST_X, SRC_ZERO, SRC_ZERO, 1'b0, 7'd0, SAT_NONE);
                if (stat.done) state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    cmd = f_alu(DST_OUT, SRC_X, SRC_ZERO, 1'b0, 7'd0, SAT_NONE);
                    m_valid_next    = 1'b1;
                    status_out_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

FILE: hw/rtl/rtd_resistance_to_temperature.sv
// Top level: RTD resistance to temperature (inverse Callendar-Van Dusen) converter.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata[31:0] resistance (Q16.16 ohms)
//  m_       | out       | m_tvalid/m_tready  | m_tdata[31:0] temperature, [34:32] status
//  cfg_     | in        | cfg_we             | cfg_index, cfg_wdata[47:0]
//
//  One transaction in gives one transaction out. Conversion time is set by the shared
//  serial units: multiply, divide (one quotient bit a cycle, the bit loop skipped for
//  a zero divisor) and root, plus ALU steps; it depends on the path: bad R0, linear,
//  quadratic, or Newton with up to 20 steps, each a polynomial, derivative and divide.
//  Reset clears the control state and loads the default sensor coefficients.
//  s_tready is high only between conversions; a finished result waits in the
//  output register, and the next transaction is taken while it waits. A second
//  finished result holds the converter until the first one leaves.
module rtd_resistance_to_temperature (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] resistance
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] temperature, [34:32] status, zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_wdata
);
    import rtd_pkg::*;

    // configuration registers: R0, A, B, C
    logic [31:0]        r0_reg;
    logic signed [47:0] coef_a_reg, coef_b_reg, coef_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_reg     <= 32'd6553600;
            coef_a_reg <= 48'sd4297221295;
            coef_b_reg <= -48'sd2600828785;
            coef_c_reg <= -48'sd19753658998;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NOMINAL: r0_reg     <= cfg_wdata[31:0];
                CFG_LINEAR:  coef_a_reg <= cfg_wdata;
                CFG_SQUARE:  coef_b_reg <= cfg_wdata;
                CFG_QUARTIC: coef_c_reg <= cfg_wdata;
                default:     r0_reg     <= r0_reg;
            endcase
        end
    end

    logic               s_accept;
    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [2:0]         status;
    logic signed [31:0] temperature;

    // a transaction enters when both sides agree
    assign s_accept = s_tvalid && s_tready;

    rtd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_accept (s_accept),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    rtd_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_load       (s_accept),
        .in_resistance (s_tdata),
        .r0            (r0_reg),
        .coef_a        (coef_a_reg),
        .coef_b        (coef_b_reg),
        .coef_c        (coef_c_reg),
        .cmd           (cmd),
        .stat          (stat),
        .temperature   (temperature)
    );

    // pack result fields from the lowest bit up
    assign m_tdata = {5'b0, status, temperature};
endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the RTD resistance to temperature converter.
`timescale 1ns / 1ps

module testbench;
    import rtd_pkg::*;

    localparam longint EST_LO = -(64'sd1 <<< 47);
    localparam longint EST_HI = (64'sd1 <<< 47) - 1;
    localparam longint T32_LO = -(64'sd1 <<< 31);
    localparam longint T32_HI = (64'sd1 <<< 31) - 1;
    localparam longint ONE_Q32 = 64'sd1 <<< 32;
    localparam int     HOLD_CYCLES = 15000;

    typedef enum logic [1:0] {PEND_ITEM, PEND_CFG, PEND_DRAIN} pend_kind_t;
    typedef struct {
        pend_kind_t  kind;
        logic [1:0]  index;
        logic [47:0] value;
    } pend_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] resistance
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [31:0] temperature, [34:32] status, zero fill
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_NOMINAL;
    logic [47:0] cfg_wdata = '0;

    // Converter settings as the testbench believes them to be
    logic [31:0] r0_set = 32'd6553600;
    longint      a_set = 64'sd4297221295;
    longint      b_set = -64'sd2600828785;
    longint      c_set = -64'sd19753658998;

    pend_t       pending[$];
    logic [34:0] expected_readings[$];   // {status, temperature}
    logic        in_taken = 1'b0;
    int          mismatches = 0;
    int          readings_seen = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    bit          calm;
    bit          cfg_now;

    rtd_resistance_to_temperature dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    // Signed divide on magnitudes; optional round to nearest, ties away from zero.
    // A zero divisor yields +/-2^126 by the sign of the numerator, or zero for a zero numerator.
    function automatic wide_t div_near(wide_t n, wide_t d, bit rnd);
        logic [127:0] un, ud, q, rm;
        bit neg;
        if (d == 0) begin
            if (n == 0) return '0;
            return (n < 0) ? -(wide_t'(1) <<< 126) : (wide_t'(1) <<< 126);
        end
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = un / ud;
        rm = un % ud;
        if (rnd && rm >= ud - rm) q = q + 1;
        return neg ? -wide_t'(q) : wide_t'(q);
    endfunction

    function automatic longint clamp_to(wide_t v, longint lo, longint hi);
        if (v < wide_t'(lo)) return lo;
        if (v > wide_t'(hi)) return hi;
        return longint'(v[63:0]);
    endfunction

    function automatic logic [63:0] root_floor(wide_t v);
        logic [63:0]  res, cand;
        logic [127:0] sq;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            sq = {64'd0, cand} * {64'd0, cand};
            if ($unsigned(v) >= sq) res = cand;
        end
        return res;
    endfunction

    // Newton-Raphson below R0; estimate kept in Q32 degrees
    function automatic longint newton_temp(longint d, longint r0, output logic [2:0] st);
        longint t, tn, delta;
        wide_t  y, a_s, b_s, b2_s, q, r1, r2, p, qd, r1d, g, stp;
        t = clamp_to(div_near(wide_t'(d) <<< 72, wide_t'(r0) * wide_t'(a_set), 1'b1),
                     EST_LO, EST_HI);
        y = div_near(wide_t'(d) <<< 56, wide_t'(r0), 1'b0);
        a_s = wide_t'(a_set) <<< 16;
        b_s = wide_t'(b_set) <<< 4;
        b2_s = wide_t'(b_set) <<< 5;
        st = STAT_NO_CONV;
        for (int k = 0; k < NEWTON_STEPS; k++) begin
            q = (wide_t'(c_set) * wide_t'(t - 100 * ONE_Q32)) >>> 48;
            r1 = b_s + ((q * wide_t'(t)) >>> 32);
            r2 = a_s + ((r1 * wide_t'(t)) >>> 32);
            p = (r2 * wide_t'(t)) >>> 32;
            qd = (wide_t'(c_set) * wide_t'(4 * t - 300 * ONE_Q32)) >>> 48;
            r1d = b2_s + ((qd * wide_t'(t)) >>> 32);
            g = a_s + ((r1d * wide_t'(t)) >>> 32);
            if (g == 0) break;
            stp = div_near((p - y) <<< 32, g, 1'b1);
            tn = clamp_to(wide_t'(t) - stp, EST_LO, EST_HI);
            delta = tn - t;
            t = tn;
            if (delta >= -1 && delta <= 1) begin
                st = STAT_OK;
                break;
            end
        end
        return clamp_to(wide_t'(t + 32768) >>> 16, T32_LO, T32_HI);
    endfunction

    function automatic logic [34:0] convert_resistance(logic [31:0] r_bits);
        longint      r, r0, d, temp, s;
        logic [2:0]  st;
        wide_t       term, disc;
        r = longint'($signed(r_bits));
        r0 = longint'({32'd0, r0_set});
        temp = 0;
        st = STAT_OK;
        if (r0 == 0) begin
            st = STAT_BAD_R0;
        end else if (r <= 0) begin
            st = STAT_RANGE;
        end else begin
            d = r - r0;
            if (d >= 0 && b_set == 0) begin
                temp = clamp_to(div_near(wide_t'(d) <<< 56, wide_t'(r0) * wide_t'(a_set), 1'b1),
                                T32_LO, T32_HI);
            end else if (d >= 0) begin
                term = div_near((wide_t'(b_set) * wide_t'(d)) <<< 30, wide_t'(r0), 1'b0);
                disc = wide_t'(a_set) * wide_t'(a_set) + term;
                if (disc < 0) begin
                    st = STAT_NEG_DISC;
                end else begin
                    s = $signed(root_floor(disc));
                    temp = clamp_to(div_near(wide_t'(s - a_set) <<< 27, wide_t'(b_set), 1'b1),
                                    T32_LO, T32_HI);
                end
            end else begin
                temp = newton_temp(d, r0, st);
            end
        end
        return {st, temp[31:0]};
    endfunction

    // ---------------- driver ----------------

    // Drive at the falling edge; hold an offered transaction until it is taken.
    always @(negedge aclk) begin
        if (aresetn) begin
            calm = readings_seen >= 300 && readings_seen < 370;
            cfg_now = 1'b0;
            if (!(s_tvalid && !in_taken)) begin
                if (pending.size() == 0 || (!calm && $urandom_range(99) < 38)) begin
                    s_tvalid <= 1'b0;
                end else if (pending[0].kind == PEND_ITEM) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending[0].value[31:0];
                    pending.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                    // Touch settings only once the block has drained
                    if (expected_readings.size() == 0 && !s_tvalid) begin
                        if (pending[0].kind == PEND_CFG) begin
                            cfg_now = 1'b1;
                            cfg_index <= pending[0].index;
                            cfg_wdata <= pending[0].value;
                            case (pending[0].index)
                                CFG_NOMINAL: r0_set = pending[0].value[31:0];
                                CFG_LINEAR:  a_set = longint'($signed(pending[0].value));
                                CFG_SQUARE:  b_set = longint'($signed(pending[0].value));
                                default:     c_set = longint'($signed(pending[0].value));
                            endcase
                        end
                        pending.pop_front();
                    end
                end
            end
            cfg_we <= cfg_now;
        end
    end

    // Receiver: random stalls, one long hold-off counted here, and a calm stretch.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && readings_seen == 150) begin
                m_tready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 38);
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_readings.push_back(convert_resistance(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            readings_seen <= readings_seen + 1;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: status %0d temperature %h",
                             m_tdata[34:32], m_tdata[31:0]);
            end else begin
                if (m_tdata[31:0] !== expected_readings[0][31:0]
                        || m_tdata[34:32] !== expected_readings[0][34:32]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reading %0d: expected status %0d temperature %h, got %0d %h",
                                 readings_seen, expected_readings[0][34:32],
                                 expected_readings[0][31:0], m_tdata[34:32], m_tdata[31:0]);
                end
                expected_readings.pop_front();
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic add_item(logic [31:0] r);
        pending.push_back('{PEND_ITEM, CFG_NOMINAL, {16'd0, r}});
    endtask

    task automatic add_cfg(logic [1:0] idx, logic [47:0] v);
        pending.push_back('{PEND_CFG, idx, v});
    endtask

    task automatic add_settings(logic [31:0] r0, longint a, longint b, longint c);
        add_cfg(CFG_NOMINAL, {16'd0, r0});
        add_cfg(CFG_LINEAR, a[47:0]);
        add_cfg(CFG_SQUARE, b[47:0]);
        add_cfg(CFG_QUARTIC, c[47:0]);
    endtask

    // Mostly readings around R0, mixed with wild values and scaled 16-bit values
    task automatic add_random(logic [31:0] r0, int n);
        longint v;
        int     sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 60)
                v = longint'({32'd0, r0}) + (longint'($signed($urandom())) >>> $urandom_range(31, 1));
            else if (sel < 80)
                v = longint'($signed($urandom()));
            else
                v = longint'($urandom_range(65535)) << $urandom_range(16);
            if (v > T32_HI) v = T32_HI;
            if (v < T32_LO) v = T32_LO;
            add_item(v[31:0]);
            if ($urandom_range(99) == 0)
                pending.push_back('{PEND_DRAIN, CFG_NOMINAL, '0});
        end
    endtask

    initial begin
        // directed readings on the reset settings
        add_item(32'd6553600);               // exactly R0
        add_item(32'd0);                     // zero resistance
        add_item(32'hFFFF_FFFF);             // negative
        add_item(32'h8000_0000);
        add_item(32'h7FFF_FFFF);
        add_item(32'd1);                     // tiny resistance
        add_item(32'd6553599);
        add_item(32'd6553601);
        add_item(32'd1213727);               // about 18.5 ohm
        add_item(32'd9076736);               // about 138.5 ohm
        add_item(32'd26214400);              // 400 ohm
        add_item(32'd3276800);
        pending.push_back('{PEND_DRAIN, CFG_NOMINAL, '0});
        // bad R0 wins over everything
        add_settings(32'd0, 64'sd4297221295, -64'sd2600828785, -64'sd19753658998);
        add_item(32'd0);
        add_item(32'd6553600);
        add_item(32'h8000_0000);
        // zero A and B: linear and initial-guess quotients divide by zero
        add_settings(32'd6553600, 0, 0, 0);
        add_item(32'd6553600);
        add_item(32'd7000000);
        add_item(32'd5000000);
        add_item(32'h7FFF_FFFF);
        // steep negative B: discriminant goes negative
        add_settings(32'd6553600, 64'sd4297221295, -(64'sd1 <<< 47), -64'sd19753658998);
        add_item(32'd13107200);
        add_item(32'h7FFF_FFFF);

        add_settings(32'd6553600, 64'sd4297221295, -64'sd2600828785, -64'sd19753658998);
        add_random(32'd6553600, 144);
        add_settings(32'd65536000, 64'sd4297221295, -64'sd2600828785, -64'sd19753658998);
        add_random(32'd65536000, 70);
        add_settings(32'd6553600, 64'sd4297221295, 0, 0);
        add_random(32'd6553600, 60);
        add_settings(32'd6553600, 0, -64'sd2600828785, -64'sd19753658998);
        add_random(32'd6553600, 50);
        add_settings(32'd6553600, (64'sd1 <<< 47) - 1, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
        add_random(32'd6553600, 50);
        add_settings(32'hFFFF_FFFF, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1, -(64'sd1 <<< 47));
        add_random(32'hFFFF_FFFF, 50);
        add_settings(32'd1, 64'sd4297221295, 64'sd2600828785, 64'sd19753658998);
        add_random(32'd1, 40);
        add_settings(32'd0, 64'sd1, 64'sd1, 64'sd1);
        add_random(32'd0, 15);
        for (int ph = 0; ph < 2; ph++) begin
            add_settings($urandom_range(32'd70000000, 32'd1000000),
                         longint'($signed({$urandom(), $urandom()})) >>> 20,
                         longint'($signed({$urandom(), $urandom()})) >>> 24,
                         longint'($signed({$urandom(), $urandom()})) >>> 20);
            add_random(32'd6553600, 40);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #400_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rtd_pkg.sv
hw/rtl/rtd_div.sv
hw/rtl/rtd_sqrt.sv
hw/rtl/rtd_dp.sv
hw/rtl/rtd_ctrl.sv
hw/rtl/rtd_resistance_to_temperature.sv
sim/testbench.sv
